// ===== hdl/vorl_pkg.sv =====
// ----------------------------------------------------------------------------
// Vote-ordered rotating list package
// Command and status codes, cell chain control and parameter defaults.
// ----------------------------------------------------------------------------
package vorl_pkg;

   localparam int CAPACITY_DEF  = 64;
   localparam int ID_BITS_DEF   = 16;
   localparam int VOTE_BITS_DEF = 16;

   localparam logic [2:0] CMD_ADD      = 3'd0;
   localparam logic [2:0] CMD_UPVOTE   = 3'd1;
   localparam logic [2:0] CMD_DOWNVOTE = 3'd2;
   localparam logic [2:0] CMD_TAKE     = 3'd3;
   localparam logic [2:0] CMD_READ     = 3'd4;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd1;
   localparam logic [2:0] STATUS_EMPTY     = 3'd2;
   localparam logic [2:0] STATUS_FULL      = 3'd3;
   localparam logic [2:0] STATUS_RANGE     = 3'd4;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_LOAD,
      OP_ROTATE,
      OP_TAKE,
      OP_SORT
   } chain_op_type;

   typedef struct packed {
      chain_op_type op;
      logic         phase;
   } chain_ctrl_type;

endpackage

// ===== hdl/vote_ordered_rotating_list_core.sv =====
// ----------------------------------------------------------------------------
// Vote-ordered rotating list core
// An ordered table of id and vote entries held in a chain of cells, with
// add, vote, take-first and read commands.
// ----------------------------------------------------------------------------
//  Channel | Direction | tuser       | tdata (lowest bit up)
//  req     | in        | cmd         | song_id, initial_votes, position
//  rsp     | out       | status      | result_id, result_votes, entry_total
//
// Refused, unused, add and take-first commands go from the idle state
// straight to the done state, which loads the output register; a read or an
// unmatched vote first makes one rotation past the front cell, and a matched
// vote then adds CAPACITY odd-even sort phases. One command is in work at a
// time; synchronous reset empties the table. A stalled result waits in
// the output register while the next command is taken.
module vote_ordered_rotating_list_core #(
   parameter int CAPACITY  = vorl_pkg::CAPACITY_DEF,
   parameter int ID_BITS   = vorl_pkg::ID_BITS_DEF,
   parameter int VOTE_BITS = vorl_pkg::VOTE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // song_id, initial_votes, position, zero pad
   input  logic [2:0]  req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // result_id, result_votes, entry_total, zero pad
   output logic [2:0]  rsp_tuser    // status
);
   import vorl_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam logic signed [32:0] VMAX_W = 33'((64'sd1 <<< (VOTE_BITS - 1)) - 64'sd1);
   localparam logic signed [32:0] VMIN_W = -VMAX_W - 33'sd1;
   localparam logic signed [VOTE_BITS-1:0] VMAX_V = VOTE_BITS'(VMAX_W);
   localparam logic signed [VOTE_BITS-1:0] VMIN_V = VOTE_BITS'(VMIN_W);
   localparam logic signed [VOTE_BITS-1:0] VOTE_ONE = VOTE_BITS'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_SORT,
      ST_DONE
   } state_type;

   state_type                   state_ff, state_in;
   logic [CNT_W-1:0]            fill_ff, fill_in;
   logic [2:0]                  cmd_ff, cmd_in;
   logic [ID_BITS-1:0]          id_ff, id_in;
   logic [5:0]                  pos_ff, pos_in;
   logic [IDX_W-1:0]            step_ff, step_in;
   logic                        phase_ff, phase_in;
   logic                        found_ff, found_in;
   logic [2:0]                  res_status_ff, res_status_in;
   logic [ID_BITS-1:0]          res_id_ff, res_id_in;
   logic signed [VOTE_BITS-1:0] res_votes_ff, res_votes_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [39:0]                 rsp_data_ff, rsp_data_in;
   logic [2:0]                  rsp_user_ff, rsp_user_in;

   chain_ctrl_type              ctrl;
   logic [ID_BITS-1:0]          req_id;
   logic signed [15:0]          req_init;
   logic signed [32:0]          init_wide;
   logic signed [VOTE_BITS-1:0] req_votes;
   logic [5:0]                  req_pos;
   logic [2:0]                  req_cmd;
   logic                        accept;
   logic                        is_vote;
   logic                        hit;
   logic                        last_step;
   logic signed [VOTE_BITS-1:0] next_votes;
   logic [ID_BITS-1:0]          head_id;
   logic signed [VOTE_BITS-1:0] head_votes;
   logic [ID_BITS-1:0]          wrap_id;
   logic signed [VOTE_BITS-1:0] wrap_votes;
   logic [15:0]                 out_id;
   logic signed [15:0]          out_votes;

   vorl_chain #(
      .CAPACITY  (CAPACITY),
      .ID_BITS   (ID_BITS),
      .VOTE_BITS (VOTE_BITS)
   ) u_chain (
      .clock      (clock),
      .ctrl       (ctrl),
      .fill       (fill_ff),
      .new_id     (req_id),
      .new_votes  (req_votes),
      .wrap_id    (wrap_id),
      .wrap_votes (wrap_votes),
      .head_id    (head_id),
      .head_votes (head_votes)
   );

   always_comb begin
      req_cmd   = req_tuser;
      req_id    = ID_BITS'(req_tdata[15:0]);
      req_init  = req_tdata[31:16];
      req_pos   = req_tdata[37:32];
      init_wide = 33'(req_init);
      if (init_wide > VMAX_W) begin
         init_wide = VMAX_W;
      end else if (init_wide < VMIN_W) begin
         init_wide = VMIN_W;
      end
      req_votes = VOTE_BITS'(init_wide);
      accept    = req_tvalid && (state_ff == ST_IDLE);

      is_vote   = (cmd_ff == CMD_UPVOTE) || (cmd_ff == CMD_DOWNVOTE);
      last_step = (step_ff == IDX_W'(CAPACITY - 1));
      hit       = is_vote && !found_ff && (CNT_W'(step_ff) < fill_ff) && (head_id == id_ff);
      if (cmd_ff == CMD_UPVOTE) begin
         next_votes = (head_votes == VMAX_V) ? head_votes : head_votes + VOTE_ONE;
      end else begin
         next_votes = (head_votes == VMIN_V) ? head_votes : head_votes - VOTE_ONE;
      end
      wrap_id    = head_id;
      wrap_votes = hit ? next_votes : head_votes;

      ctrl.op    = OP_HOLD;
      ctrl.phase = phase_ff;

      state_in      = state_ff;
      fill_in       = fill_ff;
      cmd_in        = cmd_ff;
      id_in         = id_ff;
      pos_in        = pos_ff;
      step_in       = step_ff;
      phase_in      = phase_ff;
      found_in      = found_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_votes_in  = res_votes_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in        = req_cmd;
               id_in         = req_id;
               pos_in        = req_pos;
               step_in       = '0;
               phase_in      = 1'b0;
               found_in      = 1'b0;
               res_status_in = STATUS_OK;
               res_id_in     = '0;
               res_votes_in  = '0;
               state_in      = ST_DONE;
               case (req_cmd)
                  CMD_ADD: begin
                     if (fill_ff == CNT_W'(CAPACITY)) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        ctrl.op      = OP_LOAD;
                        fill_in      = fill_ff + 1'b1;
                        res_id_in    = req_id;
                        res_votes_in = req_votes;
                     end
                  end
                  CMD_UPVOTE, CMD_DOWNVOTE: begin
                     state_in = ST_ROTATE;
                  end
                  CMD_TAKE: begin
                     if (fill_ff == '0) begin
                        res_status_in = STATUS_EMPTY;
                     end else begin
                        ctrl.op      = OP_TAKE;
                        res_id_in    = head_id;
                        res_votes_in = head_votes;
                     end
                  end
                  CMD_READ: begin
                     if (32'(req_pos) >= 32'(fill_ff)) begin
                        res_status_in = STATUS_RANGE;
                     end else begin
                        state_in = ST_ROTATE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ROTATE: begin
            ctrl.op = OP_ROTATE;
            step_in = step_ff + 1'b1;
            if (hit) begin
               found_in     = 1'b1;
               res_id_in    = id_ff;
               res_votes_in = next_votes;
            end
            if ((cmd_ff == CMD_READ) && (32'(step_ff) == 32'(pos_ff))) begin
               res_id_in    = head_id;
               res_votes_in = head_votes;
            end
            if (last_step) begin
               step_in = '0;
               if (is_vote && !(found_ff || hit)) begin
                  res_status_in = STATUS_NOT_FOUND;
                  state_in      = ST_DONE;
               end else if (is_vote) begin
                  state_in = ST_SORT;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SORT: begin
            ctrl.op  = OP_SORT;
            phase_in = !phase_ff;
            step_in  = step_ff + 1'b1;
            if (last_step) begin
               step_in  = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = res_status_ff;
               rsp_data_in  = {1'b0, 7'(fill_ff), out_votes, out_id};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign out_id    = 16'(res_id_ff);
   assign out_votes = 16'(res_votes_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      id_ff         <= id_in;
      pos_ff        <= pos_in;
      step_ff       <= step_in;
      phase_ff      <= phase_in;
      found_ff      <= found_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_votes_ff  <= res_votes_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(CAPACITY))
      else $error("Entry count exceeds the table capacity.");

   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cmd == CMD_ADD) && (fill_ff != CNT_W'(CAPACITY)))
      |=> (fill_ff == CNT_W'($past(fill_ff) + 1'b1)))
      else $error("An accepted add did not grow the table by one entry.");

   a_sort_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SORT) |-> found_ff)
      else $error("Re-sort started without a matching entry.");

endmodule

// ===== hdl/vorl_cell.sv =====
// ----------------------------------------------------------------------------
// Vote-ordered rotating list cell
// Holds one table entry; loads a new entry, or trades it with its neighbors on rotate, take and sort.
// ----------------------------------------------------------------------------
module vorl_cell #(
   parameter int INDEX     = 0,
   parameter int CAPACITY  = vorl_pkg::CAPACITY_DEF,
   parameter int ID_BITS   = vorl_pkg::ID_BITS_DEF,
   parameter int VOTE_BITS = vorl_pkg::VOTE_BITS_DEF
) (
   input  logic                                clock,
   input  vorl_pkg::chain_ctrl_type            ctrl,
   input  logic [$clog2(CAPACITY+1)-1:0]       fill,
   input  logic [ID_BITS-1:0]                  new_id,
   input  logic signed [VOTE_BITS-1:0]         new_votes,
   input  logic [ID_BITS-1:0]                  left_id,
   input  logic signed [VOTE_BITS-1:0]         left_votes,
   input  logic [ID_BITS-1:0]                  right_id,
   input  logic signed [VOTE_BITS-1:0]         right_votes,
   input  logic [ID_BITS-1:0]                  head_id,
   output logic [ID_BITS-1:0]                  cell_id,
   output logic signed [VOTE_BITS-1:0]         cell_votes
);
   import vorl_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [ID_BITS-1:0]          id_ff, id_in;
   logic signed [VOTE_BITS-1:0] votes_ff, votes_in;
   logic                        lower;
   logic                        lo_active;
   logic                        up_active;

   always_comb begin
      lower     = (1'(INDEX % 2) == ctrl.phase);
      lo_active = (CNT_W'(INDEX + 1) < fill);
      up_active = (INDEX > 0) && (CNT_W'(INDEX) < fill);
      id_in     = id_ff;
      votes_in  = votes_ff;
      unique case (ctrl.op)
         OP_HOLD: begin
         end
         OP_LOAD: begin
            if (CNT_W'(INDEX) == fill) begin
               id_in    = new_id;
               votes_in = new_votes;
            end
         end
         OP_ROTATE: begin
            id_in    = right_id;
            votes_in = right_votes;
         end
         OP_TAKE: begin
            if (lo_active) begin
               id_in    = right_id;
               votes_in = right_votes;
            end else if (CNT_W'(INDEX + 1) == fill) begin
               id_in    = head_id;
               votes_in = '0;
            end
         end
         OP_SORT: begin
            if (lower) begin
               if (lo_active && (votes_ff < right_votes)) begin
                  id_in    = right_id;
                  votes_in = right_votes;
               end
            end else if (up_active && (left_votes < votes_ff)) begin
               id_in    = left_id;
               votes_in = left_votes;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      votes_ff <= votes_in;
   end

   assign cell_id    = id_ff;
   assign cell_votes = votes_ff;

endmodule

// ===== hdl/vorl_chain.sv =====
// ----------------------------------------------------------------------------
// Vote-ordered rotating list cell chain
// A row of entry cells; the front cell is seen at the head outputs and the
// back cell is fed from the wrap inputs during a rotation.
// ----------------------------------------------------------------------------
module vorl_chain #(
   parameter int CAPACITY  = vorl_pkg::CAPACITY_DEF,
   parameter int ID_BITS   = vorl_pkg::ID_BITS_DEF,
   parameter int VOTE_BITS = vorl_pkg::VOTE_BITS_DEF
) (
   input  logic                                clock,
   input  vorl_pkg::chain_ctrl_type            ctrl,
   input  logic [$clog2(CAPACITY+1)-1:0]       fill,
   input  logic [ID_BITS-1:0]                  new_id,
   input  logic signed [VOTE_BITS-1:0]         new_votes,
   input  logic [ID_BITS-1:0]                  wrap_id,
   input  logic signed [VOTE_BITS-1:0]         wrap_votes,
   output logic [ID_BITS-1:0]                  head_id,
   output logic signed [VOTE_BITS-1:0]         head_votes
);
   import vorl_pkg::*;

   logic [ID_BITS-1:0]          id_q        [CAPACITY];
   logic signed [VOTE_BITS-1:0] votes_q     [CAPACITY];
   logic [ID_BITS-1:0]          left_id     [CAPACITY];
   logic signed [VOTE_BITS-1:0] left_votes  [CAPACITY];
   logic [ID_BITS-1:0]          right_id    [CAPACITY];
   logic signed [VOTE_BITS-1:0] right_votes [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_front
         assign left_id[i]    = id_q[i];
         assign left_votes[i] = votes_q[i];
      end else begin : g_inner_left
         assign left_id[i]    = id_q[i-1];
         assign left_votes[i] = votes_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_back
         assign right_id[i]    = wrap_id;
         assign right_votes[i] = wrap_votes;
      end else begin : g_inner_right
         assign right_id[i]    = id_q[i+1];
         assign right_votes[i] = votes_q[i+1];
      end

      vorl_cell #(
         .INDEX     (i),
         .CAPACITY  (CAPACITY),
         .ID_BITS   (ID_BITS),
         .VOTE_BITS (VOTE_BITS)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .fill        (fill),
         .new_id      (new_id),
         .new_votes   (new_votes),
         .left_id     (left_id[i]),
         .left_votes  (left_votes[i]),
         .right_id    (right_id[i]),
         .right_votes (right_votes[i]),
         .head_id     (id_q[0]),
         .cell_id     (id_q[i]),
         .cell_votes  (votes_q[i])
      );
   end

   assign head_id    = id_q[0];
   assign head_votes = votes_q[0];

endmodule
